// ===== hdl/pdd_pkg.sv =====
package pdd_pkg;

  localparam int DROP_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int TIMER_W    = 16;
  localparam int FLAG_W     = 4;
  localparam int RTS_RETRY_LIMIT = 7;

  // flag bits
  localparam int FL_MAXRTS  = 0;
  localparam int FL_MOB     = 1;
  localparam int FL_CTSWAIT = 2;
  localparam int FL_WIN     = 3;

  // input opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // frame kinds
  localparam logic [2:0] KIND_RTS  = 3'd0;
  localparam logic [2:0] KIND_CTS  = 3'd1;
  localparam logic [2:0] KIND_DATA = 3'd2;
  localparam logic [2:0] KIND_RREQ = 3'd3;

  // register indexes
  localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_WINDOW_SIZE = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;
  localparam logic [1:0] REG_WIN_TICKS   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_MUL1,
    ST_MUL2,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } pdd_state_t;

  typedef struct packed {
    logic              done;
    logic [DROP_W-1:0] drop;
  } pdd_div_res_t;

endpackage

// ===== hdl/packet_drop_detector_top.sv =====
// packet drop detector
// input channel (in_*): one transaction is an entry load, a tick or a sniffed
// frame, selected by in_op; it is taken when in_valid is high and in_stall low
// result channel (out_*): one transaction per evaluated node, ascending node
// index, out_last marks the final result caused by one input
// config: apb-style port, registers at byte addresses 0, 4, 8, 12
// sequence: a load, a tick or an ignored frame is handled without leaving idle; a
// frame walks the table one entry per cycle; an evaluation then scans the table
// one entry per cycle between evaluated nodes and, per evaluated node that has
// rx and rts counts and is not blocked, uses the shared multiplier for fwd*rts
// and then rx*cts, runs the bit-serial divider, and then hands the result out
// flow: one item at a time, in_stall stays high until the item is done
// reset: counters, flags, timers and the last stamp clear, registers return
// to 0, 16, 32768 and 1000; table addresses are undefined until loaded
// stall: a result waits in the output register while out_stall is high, and
// the evaluation holds until that register frees up
module packet_drop_detector_top import pdd_pkg::*; #(
  parameter int NODES      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_op,
  input  logic [3:0]   in_entry_index,
  input  logic [47:0]  in_entry_mac,
  input  logic [31:0]  in_entry_ip,
  input  logic [2:0]   in_frame_kind,
  input  logic [31:0]  in_stamp,
  input  logic [47:0]  in_src_mac,
  input  logic [47:0]  in_dst_mac,
  input  logic [31:0]  in_src_ip,
  input  logic [31:0]  in_dst_ip,
  input  logic [31:0]  in_origin_ip,
  // result channel
  output logic         out_valid,
  input  logic         out_stall,
  output logic [3:0]   out_node_index,
  output logic [16:0]  out_drop_prob,
  output logic         out_detected,
  output logic         out_last,
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNTW = $clog2(NODES + 1);
  localparam int CW   = COUNT_BITS;
  localparam int PW   = 2 * COUNT_BITS;
  localparam int CMPW = (CW > 16) ? CW : 16;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // configuration registers
  logic [4:0]  node_count_r;
  logic [15:0] window_size_r;
  logic [16:0] threshold_r;
  logic [15:0] window_ticks_r;
  logic        cfg_wr;

  // node table
  logic [47:0]        node_mac [NODES];
  logic [31:0]        node_ip  [NODES];
  logic [CW-1:0]      rx_r     [NODES];
  logic [CW-1:0]      fwd_r    [NODES];
  logic [CW-1:0]      rtot_r   [NODES];
  logic [CW-1:0]      ctot_r   [NODES];
  logic [CW-1:0]      rpend_r  [NODES];
  logic [CW-1:0]      cpend_r  [NODES];
  logic [CW-1:0]      rreq_r   [NODES];
  logic [FLAG_W-1:0]  flags_r  [NODES];
  logic [TIMER_W-1:0] timer_r  [NODES];
  logic [31:0]        last_stamp_r;

  // latched frame
  logic [2:0]  kind_r;
  logic [47:0] smac_r, dmac_r;
  logic [31:0] sip_r, dip_r, oip_r;

  // sequencer
  pdd_state_t       state_r, state_nxt;
  logic [CNTW-1:0]  wi_r, wi_nxt;
  logic [CNTW-1:0]  nact_r;
  logic             trig_r, trig_nxt;
  logic [NODES-1:0] elig_r, elig_nxt;
  logic [IW-1:0]    sel;
  logic             accept, is_frame_new, out_free, out_load;

  // evaluation datapath
  logic [PW-1:0]    mul_q, num_r, den_r;
  logic [CW-1:0]    mul_a, mul_b;
  logic [DROP_W-1:0] ev_drop_r, ev_drop_nxt;
  logic             ev_det_r, ev_det_nxt;
  pdd_div_res_t     div_res;

  // per-entry update for the frame walk
  logic [FLAG_W-1:0]  u_f;
  logic [CW-1:0]      u_rp, u_cp, u_rt, u_ct, u_fw, u_rx, u_rq;
  logic [TIMER_W-1:0] u_tm;
  logic               u_trig;
  logic               ev_calc, ev_blk, ev_win;

  // output register
  logic              out_valid_r;
  logic [3:0]        out_idx_r;
  logic [DROP_W-1:0] out_drop_r;
  logic              out_det_r, out_last_r;

  assign sel      = wi_r[IW-1:0];
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_frame_new = (in_op == OP_FRAME) && (in_stamp != last_stamp_r);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_OUT) && out_free;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r   <= 5'd0;
      window_size_r  <= 16'd16;
      threshold_r    <= 17'd32768;
      window_ticks_r <= 16'd1000;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NODE_COUNT:  node_count_r   <= pwdata[4:0];
        REG_WINDOW_SIZE: window_size_r  <= pwdata[15:0];
        REG_THRESHOLD:   threshold_r    <= pwdata[16:0];
        REG_WIN_TICKS:   window_ticks_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NODE_COUNT:  prdata = {27'd0, node_count_r};
      REG_WINDOW_SIZE: prdata = {16'd0, window_size_r};
      REG_THRESHOLD:   prdata = {15'd0, threshold_r};
      REG_WIN_TICKS:   prdata = {16'd0, window_ticks_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------- frame walk update for the selected entry ----------------
  always_comb begin
    u_f    = flags_r[sel];
    u_rp   = rpend_r[sel];
    u_cp   = cpend_r[sel];
    u_rt   = rtot_r[sel];
    u_ct   = ctot_r[sel];
    u_fw   = fwd_r[sel];
    u_rx   = rx_r[sel];
    u_rq   = rreq_r[sel];
    u_tm   = timer_r[sel];
    u_trig = 1'b0;
    case (kind_r)
      KIND_RTS: begin
        if (node_mac[sel] == smac_r) begin
          if (u_f[FL_MAXRTS]) begin
            u_f[FL_MAXRTS] = 1'b0;
            u_rp = '0;
            u_f[FL_MOB] = 1'b1;
          end
          u_rp = sat_add(u_rp, CW'(1));
          if (u_rp >= CW'(RTS_RETRY_LIMIT)) u_f[FL_MAXRTS] = 1'b1;
        end
      end
      KIND_CTS: begin
        if (node_mac[sel] == dmac_r && u_rp != '0) begin
          u_f[FL_CTSWAIT] = 1'b1;
          u_f[FL_MAXRTS]  = 1'b0;
          u_cp = sat_add(u_cp, CW'(1));
        end
      end
      KIND_DATA: begin
        if (node_mac[sel] == smac_r && u_f[FL_CTSWAIT]) begin
          u_ct = sat_add(u_ct, u_cp);
          u_cp = '0;
          u_rt = sat_add(u_rt, u_rp);
          u_rp = '0;
          u_f[FL_CTSWAIT] = 1'b0;
        end
        if (node_mac[sel] == smac_r && node_ip[sel] != sip_r)
          u_fw = sat_add(u_fw, CW'(1));
        if (node_mac[sel] == dmac_r && node_ip[sel] != dip_r) begin
          u_rx = sat_add(u_rx, CW'(1));
          if (CMPW'(u_rx) >= CMPW'(window_size_r)) u_trig = 1'b1;
        end
      end
      KIND_RREQ: begin
        if (node_ip[sel] == oip_r && node_ip[sel] == sip_r &&
            node_mac[sel] == smac_r && u_f[FL_MAXRTS]) begin
          u_f[FL_MAXRTS]  = 1'b0;
          u_f[FL_CTSWAIT] = 1'b0;
          u_rp = '0;
          u_cp = '0;
          u_rq = sat_add(u_rq, CW'(1));
          u_f[FL_WIN] = 1'b1;
          u_tm = window_ticks_r;
        end
      end
      default: begin
        // any other frame from the node cancels its pending handshake
        if (node_mac[sel] == smac_r && u_f[FL_CTSWAIT]) begin
          u_rp = '0;
          u_cp = '0;
          u_f[FL_CTSWAIT] = 1'b0;
        end
      end
    endcase
  end

  // evaluation gating for the selected entry
  always_comb begin
    ev_win  = flags_r[sel][FL_WIN];
    ev_calc = (rx_r[sel] != '0) && (rtot_r[sel] != '0);
    ev_blk  = flags_r[sel][FL_MOB] || (ctot_r[sel] == '0) || ev_win ||
              (rreq_r[sel] != '0);
  end

  // shared multiplier: fwd*rts first, then rx*cts
  always_comb begin
    if (state_r == ST_MUL1) begin
      mul_a = fwd_r[sel];
      mul_b = rtot_r[sel];
    end else begin
      mul_a = rx_r[sel];
      mul_b = ctot_r[sel];
    end
  end
  assign mul_q = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL1) num_r <= mul_q;
    if (state_r == ST_MUL2) den_r <= mul_q;
  end

  pdd_div #(.W(PW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIVGO),
    .num   (num_r),
    .den   (den_r),
    .res   (div_res)
  );

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt   = state_r;
    wi_nxt      = wi_r;
    trig_nxt    = trig_r;
    elig_nxt    = elig_r;
    ev_drop_nxt = ev_drop_r;
    ev_det_nxt  = ev_det_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_frame_new) begin
          wi_nxt    = '0;
          trig_nxt  = 1'b0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (wi_r >= nact_r) begin
          // table updated; if the frame triggered, collect every entry that reached the window
          wi_nxt = '0;
          for (int i = 0; i < NODES; i++)
            elig_nxt[i] = trig_r && (CNTW'(i) < nact_r) &&
                          (CMPW'(rx_r[i]) >= CMPW'(window_size_r));
          state_nxt = (trig_r && (elig_nxt != '0)) ? ST_SCAN : ST_IDLE;
        end else begin
          trig_nxt = trig_r || u_trig;
          wi_nxt   = wi_r + CNTW'(1);
        end
      end
      ST_SCAN: begin
        if (elig_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!elig_r[sel]) begin
          wi_nxt = wi_r + CNTW'(1);
        end else if (!ev_calc) begin
          ev_drop_nxt = '0;
          ev_det_nxt  = 1'b0;
          state_nxt   = ST_OUT;
        end else if (ev_blk) begin
          ev_drop_nxt = '0;
          ev_det_nxt  = (threshold_r == '0) && !ev_win;
          state_nxt   = ST_OUT;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_res.done) begin
          ev_drop_nxt = div_res.drop;
          ev_det_nxt  = (div_res.drop >= threshold_r);
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          elig_nxt[sel] = 1'b0;
          wi_nxt        = wi_r + CNTW'(1);
          state_nxt     = (elig_nxt == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      trig_r  <= 1'b0;
      elig_r  <= '0;
    end else begin
      state_r <= state_nxt;
      trig_r  <= trig_nxt;
      elig_r  <= elig_nxt;
    end
    wi_r      <= wi_nxt;
    ev_drop_r <= ev_drop_nxt;
    ev_det_r  <= ev_det_nxt;
  end

  // latch the frame and the active entry count
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_frame_kind;
      smac_r <= in_src_mac;
      dmac_r <= in_dst_mac;
      sip_r  <= in_src_ip;
      dip_r  <= in_dst_ip;
      oip_r  <= in_origin_ip;
      nact_r <= (32'(node_count_r) > NODES) ? CNTW'(NODES) : CNTW'(node_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) last_stamp_r <= '0;
    else if (accept && is_frame_new) last_stamp_r <= in_stamp;
  end

  // ---------------- node table addresses ----------------
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD && 32'(in_entry_index) < NODES) begin
      node_mac[IW'(in_entry_index)] <= in_entry_mac;
      node_ip[IW'(in_entry_index)]  <= in_entry_ip;
    end
  end

  // ---------------- node table counters ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        rx_r[i]    <= '0;
        fwd_r[i]   <= '0;
        rtot_r[i]  <= '0;
        ctot_r[i]  <= '0;
        rpend_r[i] <= '0;
        cpend_r[i] <= '0;
        rreq_r[i]  <= '0;
        flags_r[i] <= '0;
        timer_r[i] <= '0;
      end
    end else if (accept && in_op == OP_LOAD) begin
      if (32'(in_entry_index) < NODES) begin
        rx_r[IW'(in_entry_index)]    <= '0;
        fwd_r[IW'(in_entry_index)]   <= '0;
        rtot_r[IW'(in_entry_index)]  <= '0;
        ctot_r[IW'(in_entry_index)]  <= '0;
        rpend_r[IW'(in_entry_index)] <= '0;
        cpend_r[IW'(in_entry_index)] <= '0;
        rreq_r[IW'(in_entry_index)]  <= '0;
        flags_r[IW'(in_entry_index)] <= '0;
        timer_r[IW'(in_entry_index)] <= '0;
      end
    end else if (accept && in_op == OP_TICK) begin
      // every open window counts down in parallel
      for (int i = 0; i < NODES; i++) begin
        if (flags_r[i][FL_WIN]) begin
          if (timer_r[i] <= TIMER_W'(1)) begin
            flags_r[i][FL_WIN] <= 1'b0;
            timer_r[i]         <= '0;
          end else begin
            timer_r[i] <= timer_r[i] - TIMER_W'(1);
          end
        end
      end
    end else if (state_r == ST_WALK && wi_r < nact_r) begin
      rx_r[sel]    <= u_rx;
      fwd_r[sel]   <= u_fw;
      rtot_r[sel]  <= u_rt;
      ctot_r[sel]  <= u_ct;
      rpend_r[sel] <= u_rp;
      cpend_r[sel] <= u_cp;
      rreq_r[sel]  <= u_rq;
      flags_r[sel] <= u_f;
      timer_r[sel] <= u_tm;
    end else if (out_load) begin
      // evaluated node starts a fresh window, open rreq window survives
      rx_r[sel]    <= '0;
      fwd_r[sel]   <= '0;
      rtot_r[sel]  <= '0;
      ctot_r[sel]  <= '0;
      rpend_r[sel] <= '0;
      cpend_r[sel] <= '0;
      rreq_r[sel]  <= '0;
      flags_r[sel] <= flags_r[sel] & FLAG_W'(1 << FL_WIN);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_idx_r  <= 4'(wi_r);
      out_drop_r <= ev_drop_r;
      out_det_r  <= ev_det_r;
      out_last_r <= (elig_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node_index = out_idx_r;
  assign out_drop_prob  = out_drop_r;
  assign out_detected   = out_det_r;
  assign out_last       = out_last_r;

  // ---------------- assertions ----------------
  a_last_ends_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && elig_nxt == '0) |=> (state_r == ST_IDLE))
    else $error("evaluation continued after last result");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (elig_r == '0))
    else $error("pending evaluations left while idle");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside of division state");

  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drop_r <= DROP_W'(1 << FRAC_BITS)))
    else $error("drop estimate out of range");

endmodule

// ===== hdl/pdd_div.sv =====
module pdd_div import pdd_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output pdd_div_res_t res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [FRAC_BITS-1:0] q_r, q_nxt;
  logic [DROP_W-1:0]    drop_r, drop_nxt;
  logic [W:0]           dbl;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    drop_nxt = drop_r;
    dbl      = {rem_r, 1'b0};
    if (start) begin
      rem_nxt  = num;
      q_nxt    = '0;
      cnt_nxt  = '0;
      drop_nxt = '0;
      busy_nxt = (num < den);
      done_nxt = (num >= den);
    end else if (busy_r) begin
      // one quotient bit per cycle
      if (dbl >= {1'b0, den}) begin
        rem_nxt = W'(dbl - {1'b0, den});
        q_nxt   = {q_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = W'(dbl);
        q_nxt   = {q_r[FRAC_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        drop_nxt = DROP_W'(1 << FRAC_BITS) - DROP_W'(q_nxt)
                   - DROP_W'(rem_nxt != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    drop_r <= drop_nxt;
  end

  assign res.done = done_r;
  assign res.drop = drop_r;

endmodule
